@@ sv/hsv2rgb_pkg.sv @@
`default_nettype none

package hsv2rgb_pkg;

  // Field widths
  localparam int HUE_W = 9;
  localparam int SAT_W = 7;
  localparam int BRI_W = 15;
  localparam int CH_W  = 8;
  localparam int NUM_CH = 3;

  // Hue geometry
  localparam int SECTOR_DEG = 60;
  localparam int GAP_W      = 6;

  // Channel weight k: 6000 for chroma+m, 6000-60*s for m alone, 6000-s*gap
  // for ramp+m. Range -1620..6000 as a signed value.
  localparam int FULL_K = 100 * SECTOR_DEG;
  localparam int KS_W   = 14;

  // floor(255*b*k/153600000) = floor(17*b*k / (2^14 * 625))
  localparam int GAIN        = 17;
  localparam int K_W         = 17;
  localparam int PROD_W      = 32;
  localparam int PRE_SHIFT   = 14;
  localparam int QUOT_W      = PROD_W - PRE_SHIFT;
  localparam int DIV_CONST   = 625;
  localparam int SAT_LIMIT   = 256 * DIV_CONST;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP       = 429497;
  localparam int RECIP_W     = 19;
  localparam int REC_PROD_W  = QUOT_W + RECIP_W;

  // Queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Classified item travelling from the front to the back
  typedef struct packed {
    logic [BRI_W-1:0]             brightness;
    logic [NUM_CH-1:0][K_W-1:0]   kp;
  } item_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // Lane order
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

endpackage

`default_nettype wire

@@ sv/hsv2rgb_fifo.sv @@
`default_nettype none

module hsv2rgb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ sv/hsv2rgb_front.sv @@
`default_nettype none

module hsv2rgb_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [hsv2rgb_pkg::HUE_W-1:0]  in_hue,
  input  wire logic [hsv2rgb_pkg::SAT_W-1:0]  in_saturation,
  input  wire logic [hsv2rgb_pkg::BRI_W-1:0]  in_brightness,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output hsv2rgb_pkg::item_t                  out_item
);

  import hsv2rgb_pkg::*;

  typedef enum logic [2:0] {
    SEC_R_Y,
    SEC_Y_G,
    SEC_G_C,
    SEC_C_B,
    SEC_B_M,
    SEC_M_R
  } sector_t;

  localparam logic [HUE_W-1:0] DEG_1 = HUE_W'(SECTOR_DEG);
  localparam logic [HUE_W-1:0] DEG_2 = HUE_W'(2 * SECTOR_DEG);
  localparam logic [HUE_W-1:0] DEG_3 = HUE_W'(3 * SECTOR_DEG);
  localparam logic [HUE_W-1:0] DEG_4 = HUE_W'(4 * SECTOR_DEG);
  localparam logic [HUE_W-1:0] DEG_5 = HUE_W'(5 * SECTOR_DEG);
  localparam logic [HUE_W-1:0] DEG_6 = HUE_W'(6 * SECTOR_DEG);
  localparam logic [HUE_W-1:0] DEG_8 = HUE_W'(8 * SECTOR_DEG);
  localparam int SD_W = SAT_W + GAP_W;

  sector_t                sector;
  logic [HUE_W-1:0]       rem;
  logic [HUE_W-1:0]       gap_wide;
  logic [GAP_W-1:0]       gap;
  logic [SD_W-1:0]        s_gap;
  logic [SD_W-1:0]        s_full;
  logic signed [KS_W-1:0] k_x;
  logic signed [KS_W-1:0] k_z;
  logic [K_W-1:0]         kp_c, kp_x, kp_z;
  item_t                  item_nxt;
  item_t                  item_r;
  logic                   valid_r;

  // Scale a positive weight by the gain, clamp the rest to zero
  function automatic logic [K_W-1:0] scale_k(input logic signed [KS_W-1:0] k);
    logic [K_W-1:0] mag;
    mag = K_W'(unsigned'(k));
    if (k > 0) begin
      return mag * K_W'(GAIN);
    end
    return '0;
  endfunction

  // Classify hue into a sector; anything past the last boundary stays there
  always_comb begin
    if (in_hue < DEG_1)      sector = SEC_R_Y;
    else if (in_hue < DEG_2) sector = SEC_Y_G;
    else if (in_hue < DEG_3) sector = SEC_G_C;
    else if (in_hue < DEG_4) sector = SEC_C_B;
    else if (in_hue < DEG_5) sector = SEC_B_M;
    else                     sector = SEC_M_R;
  end

  // Reduce hue modulo two sectors, then distance from the sector edge
  always_comb begin
    if (in_hue >= DEG_8)      rem = in_hue - DEG_8;
    else if (in_hue >= DEG_6) rem = in_hue - DEG_6;
    else if (in_hue >= DEG_4) rem = in_hue - DEG_4;
    else if (in_hue >= DEG_2) rem = in_hue - DEG_2;
    else                      rem = in_hue;
    gap_wide = (rem >= DEG_1) ? rem - DEG_1 : DEG_1 - rem;
    gap      = gap_wide[GAP_W-1:0];
  end

  // Channel weights
  always_comb begin
    s_gap  = SD_W'(in_saturation) * SD_W'(gap);
    s_full = SD_W'(in_saturation) * SD_W'(SECTOR_DEG);
    k_x    = KS_W'(FULL_K) - $signed({1'b0, s_gap});
    k_z    = KS_W'(FULL_K) - $signed({1'b0, s_full});
    kp_c   = K_W'(FULL_K * GAIN);
    kp_x   = scale_k(k_x);
    kp_z   = scale_k(k_z);
  end

  // Place chroma, ramp and zero on the channels
  always_comb begin
    item_nxt.brightness = in_brightness;
    unique case (sector)
      SEC_R_Y: begin
        item_nxt.kp[CH_RED] = kp_c; item_nxt.kp[CH_GREEN] = kp_x;
        item_nxt.kp[CH_BLUE] = kp_z;
      end
      SEC_Y_G: begin
        item_nxt.kp[CH_RED] = kp_x; item_nxt.kp[CH_GREEN] = kp_c;
        item_nxt.kp[CH_BLUE] = kp_z;
      end
      SEC_G_C: begin
        item_nxt.kp[CH_RED] = kp_z; item_nxt.kp[CH_GREEN] = kp_c;
        item_nxt.kp[CH_BLUE] = kp_x;
      end
      SEC_C_B: begin
        item_nxt.kp[CH_RED] = kp_z; item_nxt.kp[CH_GREEN] = kp_x;
        item_nxt.kp[CH_BLUE] = kp_c;
      end
      SEC_B_M: begin
        item_nxt.kp[CH_RED] = kp_x; item_nxt.kp[CH_GREEN] = kp_z;
        item_nxt.kp[CH_BLUE] = kp_c;
      end
      default: begin
        item_nxt.kp[CH_RED] = kp_c; item_nxt.kp[CH_GREEN] = kp_z;
        item_nxt.kp[CH_BLUE] = kp_x;
      end
    endcase
  end

  // Output register: load when empty or draining
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/hsv2rgb_back.sv @@
`default_nettype none

module hsv2rgb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hsv2rgb_pkg::item_t in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hsv2rgb_pkg::pixel_t out_pixel
);

  import hsv2rgb_pkg::*;

  logic                                 adv1, adv2;
  logic                                 v1_r, v2_r;
  logic [PROD_W-1:0]                    prod0 [NUM_CH];
  logic [NUM_CH-1:0][QUOT_W-1:0]        quot_r, quot_nxt;
  logic [NUM_CH-1:0][REC_PROD_W-1:0]    rprod_r, rprod_nxt;
  logic [NUM_CH-1:0]                    sat_r, sat_nxt;

  // Stall control: each stage moves when the one after has room
  assign adv2      = !v2_r || out_ready;
  assign adv1      = !v1_r || adv2;
  assign in_ready  = adv1;
  assign out_valid = v2_r;

  // Stage 1: brightness times weight, drop the power-of-two part
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod0[i]    = PROD_W'(in_item.brightness) * PROD_W'(in_item.kp[i]);
      quot_nxt[i] = prod0[i][PRE_SHIFT +: QUOT_W];
    end
  end

  // Stage 2: divide by the odd part through its reciprocal, flag overflow
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sat_nxt[i]   = (quot_r[i] >= QUOT_W'(SAT_LIMIT));
      rprod_nxt[i] = REC_PROD_W'(quot_r[i]) * REC_PROD_W'(RECIP);
    end
  end

  // Clamp to full scale
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      out_pixel[i] = sat_r[i] ? {CH_W{1'b1}} : rprod_r[i][RECIP_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      quot_r <= quot_nxt;
    end
    if (adv2 && v1_r) begin
      rprod_r <= rprod_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/hsv_to_rgb_converter_core.sv @@
// Path of an item: front register, mid queue, back stages 1 and 2, output queue.
// Throughput: one item per cycle when not stalled, set by the two-stage
// multiply pipeline in the back part; the mid and output queues absorb
// stalls on either side. Reset (rst_n, synchronous, active low) empties both
// queues and clears all stage valid flags; no state survives an item.
`default_nettype none

module hsv_to_rgb_converter_core #(
  parameter int MID_DEPTH = hsv2rgb_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = hsv2rgb_pkg::OUT_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [hsv2rgb_pkg::HUE_W-1:0] in_hue,
  input  wire logic [hsv2rgb_pkg::SAT_W-1:0] in_saturation,
  input  wire logic [hsv2rgb_pkg::BRI_W-1:0] in_brightness,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [hsv2rgb_pkg::CH_W-1:0]       out_red,
  output logic [hsv2rgb_pkg::CH_W-1:0]       out_green,
  output logic [hsv2rgb_pkg::CH_W-1:0]       out_blue
);

  import hsv2rgb_pkg::*;

  logic   front_ready, front_v;
  item_t  front_item;
  logic   mid_full, mid_empty;
  item_t  mid_item;
  logic   back_ready, back_v;
  pixel_t back_pixel;
  logic   out_full_q;
  pixel_t out_pixel;

  assign in_full = !front_ready;

  // Classify hue and build channel weights
  hsv2rgb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_push),
    .in_ready      (front_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (front_v),
    .out_ready     (!mid_full),
    .out_item      (front_item)
  );

  // Decouple front from back
  hsv2rgb_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_v),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (back_ready),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  // Scale and divide per channel
  hsv2rgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!mid_empty),
    .in_ready  (back_ready),
    .in_item   (mid_item),
    .out_valid (back_v),
    .out_ready (!out_full_q),
    .out_pixel (back_pixel)
  );

  // Hold finished items for the consumer
  hsv2rgb_fifo #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_v),
    .wdata (back_pixel),
    .full  (out_full_q),
    .pop   (out_pop),
    .rdata (out_pixel),
    .empty (out_empty)
  );

  assign out_red   = out_pixel[CH_RED];
  assign out_green = out_pixel[CH_GREEN];
  assign out_blue  = out_pixel[CH_BLUE];

  // A stalled front item must hold until the mid queue takes it
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    front_v && mid_full |=> front_v && $stable(front_item))
    else $error("front item changed while stalled");

  // A stalled back result must hold until the output queue takes it
  a_back_hold: assert property (@(posedge clk) disable iff (!rst_n)
    back_v && out_full_q |=> back_v && $stable(back_pixel))
    else $error("back result changed while stalled");

  // An accepted item lands in the front register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> front_v)
    else $error("accepted item lost at front");

  // Reset leaves nothing in flight
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !front_v && !back_v)
    else $error("items present after reset");

endmodule

`default_nettype wire

@@ tb/hsv_to_rgb_converter_core_tb.sv @@
`timescale 1ns / 100ps

module hsv_to_rgb_converter_core_tb;

  localparam int FULL_SCALE  = 255;
  localparam int UNIT_DENOM  = 153600000;
  localparam int IDLE_PCT    = 28;
  localparam int DRAIN_LIMIT = 2000;

  typedef struct packed {
    logic [hsv2rgb_pkg::CH_W-1:0] red;
    logic [hsv2rgb_pkg::CH_W-1:0] green;
    logic [hsv2rgb_pkg::CH_W-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [hsv2rgb_pkg::HUE_W-1:0] in_hue = '0;
  logic [hsv2rgb_pkg::SAT_W-1:0] in_saturation = '0;
  logic [hsv2rgb_pkg::BRI_W-1:0] in_brightness = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [hsv2rgb_pkg::CH_W-1:0] out_red;
  logic [hsv2rgb_pkg::CH_W-1:0] out_green;
  logic [hsv2rgb_pkg::CH_W-1:0] out_blue;

  rgb_t colour_q[$];
  rgb_t expected_colour;
  int   mismatch_count = 0;
  bit   send_idle_on = 1'b1;
  bit   recv_idle_on = 1'b1;
  int   pop_hold_cycles = 0;
  int   hue_edges[12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};

  hsv_to_rgb_converter_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One channel: floor(255 * (part + offset) / unit), clamped to 0..255
  function automatic logic [hsv2rgb_pkg::CH_W-1:0] channel_level(longint part, longint offset);
    longint num;
    longint quot;
    num = (part + offset) * FULL_SCALE;
    if (num <= 0) return '0;
    quot = num / UNIT_DENOM;
    if (quot > FULL_SCALE) quot = FULL_SCALE;
    return quot[hsv2rgb_pkg::CH_W-1:0];
  endfunction

  // Exact rational conversion in units of 1/153600000
  function automatic rgb_t predict_colour(logic [hsv2rgb_pkg::HUE_W-1:0] hue,
                                          logic [hsv2rgb_pkg::SAT_W-1:0] sat,
                                          logic [hsv2rgb_pkg::BRI_W-1:0] bri);
    longint h;
    longint s;
    longint b;
    longint edge_gap;
    longint chroma;
    longint ramp;
    longint floor_m;
    longint r;
    longint g;
    longint bl;
    rgb_t   colour;
    h = hue;
    s = sat;
    b = bri;
    edge_gap = (h % (2 * hsv2rgb_pkg::SECTOR_DEG)) - hsv2rgb_pkg::SECTOR_DEG;
    if (edge_gap < 0) edge_gap = -edge_gap;
    chroma  = s * b * hsv2rgb_pkg::SECTOR_DEG;
    ramp    = s * b * (hsv2rgb_pkg::SECTOR_DEG - edge_gap);
    floor_m = b * (100 - s) * hsv2rgb_pkg::SECTOR_DEG;
    // Place chroma and ramp by sector; anything past 300 stays in the last one
    if (h < 60) begin
      r = chroma; g = ramp; bl = 0;
    end else if (h < 120) begin
      r = ramp; g = chroma; bl = 0;
    end else if (h < 180) begin
      r = 0; g = chroma; bl = ramp;
    end else if (h < 240) begin
      r = 0; g = ramp; bl = chroma;
    end else if (h < 300) begin
      r = ramp; g = 0; bl = chroma;
    end else begin
      r = chroma; g = 0; bl = ramp;
    end
    colour.red   = channel_level(r, floor_m);
    colour.green = channel_level(g, floor_m);
    colour.blue  = channel_level(bl, floor_m);
    return colour;
  endfunction

  task automatic report_mismatch(string what, int expected_val, int got_val);
    mismatch_count++;
    if (mismatch_count <= 200)
      $display("%0t: %s: expected %0d, got %0d", $time, what, expected_val, got_val);
  endtask

  // Offer one item at the falling edge, hold it until taken
  task automatic send_colour(logic [hsv2rgb_pkg::HUE_W-1:0] hue,
                             logic [hsv2rgb_pkg::SAT_W-1:0] sat,
                             logic [hsv2rgb_pkg::BRI_W-1:0] bri);
    bit accepted;
    accepted = 1'b0;
    @(negedge clk);
    while (send_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push       = 1'b1;
    in_hue        = hue;
    in_saturation = sat;
    in_brightness = bri;
    while (!accepted) begin
      @(posedge clk);
      if (!in_full) begin
        accepted = 1'b1;
        colour_q.push_back(predict_colour(hue, sat, bri));
      end else begin
        @(negedge clk);
      end
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_push = 1'b0;
  endtask

  // Receiver: a hold-off when one is set, else random stalls or none
  always @(negedge clk) begin
    if (pop_hold_cycles > 0) begin
      out_pop = 1'b0;
      pop_hold_cycles--;
    end else if (recv_idle_on) begin
      out_pop = ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_pop = 1'b1;
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (colour_q.size() == 0) begin
        report_mismatch("result with nothing expected, red", 0, out_red);
      end else begin
        expected_colour = colour_q.pop_front();
        if (out_red !== expected_colour.red)
          report_mismatch("red", expected_colour.red, out_red);
        if (out_green !== expected_colour.green)
          report_mismatch("green", expected_colour.green, out_green);
        if (out_blue !== expected_colour.blue)
          report_mismatch("blue", expected_colour.blue, out_blue);
      end
    end
  end

  // Corners, every sector edge, and the out-of-range inputs
  task automatic test_directed();
    send_colour(0, 0, 0);
    send_colour(0, 100, 25600);
    send_colour(359, 100, 25600);
    foreach (hue_edges[i]) send_colour(hsv2rgb_pkg::HUE_W'(hue_edges[i]), 100, 25600);
    send_colour(200, 0, 25600);
    send_colour(90, 50, 12800);
    // hue past 359 lands in the last sector
    send_colour(360, 100, 25600);
    send_colour(511, 100, 25600);
    // brightness past full scale clamps high
    send_colour(30, 40, 32767);
    // saturation past 100 drives the offset negative
    send_colour(150, 127, 25600);
    send_colour(270, 101, 20000);
    send_colour(511, 127, 32767);
  endtask

  // In-range colours, with a bias towards the edges
  task automatic test_random_legal(int count);
    logic [hsv2rgb_pkg::HUE_W-1:0] hue;
    logic [hsv2rgb_pkg::SAT_W-1:0] sat;
    logic [hsv2rgb_pkg::BRI_W-1:0] bri;
    repeat (count) begin
      if ($urandom_range(99) < 30) hue = hsv2rgb_pkg::HUE_W'(hue_edges[$urandom_range(11)]);
      else hue = hsv2rgb_pkg::HUE_W'($urandom_range(359));
      if ($urandom_range(99) < 15) sat = hsv2rgb_pkg::SAT_W'($urandom_range(1) ? 100 : 0);
      else sat = hsv2rgb_pkg::SAT_W'($urandom_range(100));
      if ($urandom_range(99) < 15) bri = hsv2rgb_pkg::BRI_W'($urandom_range(1) ? 25600 : 0);
      else bri = hsv2rgb_pkg::BRI_W'($urandom_range(25600));
      send_colour(hue, sat, bri);
    end
  endtask

  // Any bit pattern the ports can carry
  task automatic test_random_full(int count);
    repeat (count) send_colour(hsv2rgb_pkg::HUE_W'($urandom_range(511)),
                               hsv2rgb_pkg::SAT_W'($urandom_range(127)),
                               hsv2rgb_pkg::BRI_W'($urandom_range(32767)));
  endtask

  // Back-to-back on both sides
  task automatic test_no_idle(int count);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_random_legal(count);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // Fill the block behind a stalled receiver, then let it drain fully
  task automatic test_backpressure();
    send_idle_on    = 1'b0;
    pop_hold_cycles = 80;
    test_random_full(40);
    send_idle_on = 1'b1;
    release_input();
    wait (colour_q.size() == 0);
    test_random_legal(30);
    release_input();
    wait (colour_q.size() == 0);
  endtask

  initial begin
    int drain_cycles;
    drain_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_legal(900);
    test_random_full(300);
    test_no_idle(150);
    test_backpressure();
    release_input();

    // Drain, then allow for the pipeline latency
    while (colour_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (colour_q.size() != 0)
      report_mismatch("results never delivered", 0, colour_q.size());

    if (mismatch_count == 0) begin
      $display("[hsv_to_rgb_converter_core] OK");
    end else begin
      $display("[hsv_to_rgb_converter_core] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("[hsv_to_rgb_converter_core] ERROR");
    $finish;
  end

endmodule
